### sv/increasing_run_tracker_top_defines.svh
// Assertion macros used by the checker file.
`ifndef INCREASING_RUN_TRACKER_TOP_DEFINES_SVH
`define INCREASING_RUN_TRACKER_TOP_DEFINES_SVH

// Implication checked outside reset.
`define IRT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("irt assertion failed");

// Next-cycle implication checked outside reset.
`define IRT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("irt assertion failed");

// Behaviour across the reset edge.
`define IRT_ASSERT_RST(lbl, cons) \
  lbl: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
    else $error("irt reset assertion failed");

`endif

### sv/irt_pkg.sv
package irt_pkg;

  localparam int SAMPLE_WIDTH = 16;
  localparam int COUNT_WIDTH  = 16;
  localparam int CFG_WIDTH    = 16;

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic [COUNT_WIDTH-1:0]         count_t;
  typedef logic [CFG_WIDTH-1:0]           cfg_t;

  localparam cfg_t MIN_RUN_RESET = cfg_t'(2);

  typedef struct packed {
    sample_t sample;
    logic    end_of_stream;
  } irt_in_t;

  typedef struct packed {
    logic   run_closed;
    count_t run_length;
    count_t run_start;
    count_t run_end;
    count_t runs_so_far;
    count_t best_run_number;
    count_t best_start;
    count_t best_end;
    logic   stream_done;
  } irt_out_t;

endpackage

### sv/increasing_run_tracker_top.sv
// Strictly increasing run tracker.
// Input channel in_valid/in_stall/in_item carries one signed sample per item, or an
// end item (end_of_stream set) that closes the stream. Result channel
// out_valid/out_stall/out_item gives one result when a qualifying run is broken and
// one summary (stream_done set) per end item; other items give no result.
// cfg_wr_en/cfg_wr_data write min_run_length; write only while the block is idle.
// An accepted item is evaluated from the input register; its result goes to the output
// register, or the spare register while the receiver stalls. One item per cycle while
// in_stall is low, set by the single compare-and-update step between the input and
// output registers; run state is one set of registers updated once per item.
// The output register is backed by one spare result register, so a stalled receiver
// does not stop the input until both hold results; in_stall then rises, and an item
// in the input register waits there. A stalled result holds its value.
// Synchronous reset clears the run state, the pipeline and output valids, and sets
// min_run_length to 2. After an end item the run state returns to its reset values;
// min_run_length keeps its value.
module increasing_run_tracker_top (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  irt_pkg::cfg_t          cfg_wr_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  irt_pkg::irt_in_t       in_item,
  output logic                   out_valid,
  input  logic                   out_stall,
  output irt_pkg::irt_out_t      out_item
);

  function automatic irt_pkg::count_t sat_inc(input irt_pkg::count_t v);
    return (v == '1) ? v : irt_pkg::count_t'(v + 1'b1);
  endfunction

  irt_pkg::cfg_t     min_len_r;
  logic              in_valid_r;
  irt_pkg::irt_in_t  in_item_r;

  irt_pkg::sample_t  prev_r, prev_nxt;
  logic              have_first_r, have_first_nxt;
  irt_pkg::count_t   position_r, position_nxt;
  irt_pkg::count_t   cur_len_r, cur_len_nxt;
  irt_pkg::count_t   cur_start_r, cur_start_nxt;
  irt_pkg::count_t   run_count_r, run_count_nxt;
  irt_pkg::count_t   best_len_r, best_len_nxt;
  irt_pkg::count_t   best_num_r, best_num_nxt;
  irt_pkg::count_t   best_first_r, best_first_nxt;
  irt_pkg::count_t   best_last_r, best_last_nxt;

  logic              out_valid_r;
  irt_pkg::irt_out_t out_r;
  logic              skid_valid_r;
  irt_pkg::irt_out_t skid_r;

  logic              fire;
  logic              in_acc;
  logic              out_free;
  logic              res_valid;
  irt_pkg::irt_out_t res;
  logic              load_out;
  logic              load_skid;

  logic              is_end;
  logic              rising;
  logic              qual;
  logic              better;
  logic              do_close;
  irt_pkg::count_t   pos_inc;
  irt_pkg::count_t   upd_count;

  assign in_stall  = in_valid_r && skid_valid_r;
  assign fire      = in_valid_r && !skid_valid_r;
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign load_out  = out_free && (skid_valid_r || (fire && res_valid));
  assign load_skid = !out_free && fire && res_valid;

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  always_comb begin
    is_end    = in_item_r.end_of_stream;
    rising    = in_item_r.sample > prev_r;
    qual      = cur_len_r >= min_len_r;
    better    = cur_len_r > best_len_r;
    pos_inc   = sat_inc(position_r);
    do_close  = have_first_r && qual && (is_end || !rising);
    upd_count = do_close ? sat_inc(run_count_r) : run_count_r;
    res_valid = is_end || do_close;

    res                 = '0;
    res.run_closed      = do_close;
    res.stream_done     = is_end;
    res.runs_so_far     = upd_count;
    res.best_run_number = best_num_r;
    res.best_start      = best_first_r;
    res.best_end        = best_last_r;
    if (do_close) begin
      res.run_length = cur_len_r;
      res.run_start  = cur_start_r;
      res.run_end    = position_r;
      if (better) begin
        res.best_run_number = upd_count;
        res.best_start      = cur_start_r;
        res.best_end        = position_r;
      end
    end
  end

  always_comb begin
    prev_nxt       = prev_r;
    have_first_nxt = have_first_r;
    position_nxt   = position_r;
    cur_len_nxt    = cur_len_r;
    cur_start_nxt  = cur_start_r;
    run_count_nxt  = run_count_r;
    best_len_nxt   = best_len_r;
    best_num_nxt   = best_num_r;
    best_first_nxt = best_first_r;
    best_last_nxt  = best_last_r;
    if (fire) begin
      if (is_end) begin
        prev_nxt       = '0;
        have_first_nxt = 1'b0;
        position_nxt   = '0;
        cur_len_nxt    = irt_pkg::count_t'(1);
        cur_start_nxt  = '0;
        run_count_nxt  = '0;
        best_len_nxt   = '0;
        best_num_nxt   = '0;
        best_first_nxt = '0;
        best_last_nxt  = '0;
      end else if (!have_first_r) begin
        have_first_nxt = 1'b1;
        position_nxt   = pos_inc;
        prev_nxt       = in_item_r.sample;
        cur_start_nxt  = pos_inc;
        cur_len_nxt    = irt_pkg::count_t'(1);
      end else begin
        position_nxt = pos_inc;
        prev_nxt     = in_item_r.sample;
        if (rising) begin
          cur_len_nxt = sat_inc(cur_len_r);
        end else begin
          cur_len_nxt   = irt_pkg::count_t'(1);
          cur_start_nxt = pos_inc;
          run_count_nxt = upd_count;
          if (do_close && better) begin
            best_len_nxt   = cur_len_r;
            best_num_nxt   = upd_count;
            best_first_nxt = cur_start_r;
            best_last_nxt  = position_r;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_len_r    <= irt_pkg::MIN_RUN_RESET;
      in_valid_r   <= 1'b0;
      prev_r       <= '0;
      have_first_r <= 1'b0;
      position_r   <= '0;
      cur_len_r    <= irt_pkg::count_t'(1);
      cur_start_r  <= '0;
      run_count_r  <= '0;
      best_len_r   <= '0;
      best_num_r   <= '0;
      best_first_r <= '0;
      best_last_r  <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        min_len_r <= cfg_wr_data;
      end
      if (in_acc) begin
        in_valid_r <= 1'b1;
      end else if (fire) begin
        in_valid_r <= 1'b0;
      end
      prev_r       <= prev_nxt;
      have_first_r <= have_first_nxt;
      position_r   <= position_nxt;
      cur_len_r    <= cur_len_nxt;
      cur_start_r  <= cur_start_nxt;
      run_count_r  <= run_count_nxt;
      best_len_r   <= best_len_nxt;
      best_num_r   <= best_num_nxt;
      best_first_r <= best_first_nxt;
      best_last_r  <= best_last_nxt;
      if (out_free) begin
        out_valid_r <= load_out;
      end
      if (load_skid) begin
        skid_valid_r <= 1'b1;
      end else if (out_free) begin
        skid_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_item_r <= in_item;
    end
    if (load_out) begin
      out_r <= skid_valid_r ? skid_r : res;
    end
    if (load_skid) begin
      skid_r <= res;
    end
  end

endmodule

### sv/irt_checker.sv
`include "increasing_run_tracker_top_defines.svh"

module irt_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_stall,
  input irt_pkg::irt_out_t out_item
);

  logic span_ok;

  assign span_ok = (out_item.runs_so_far != '0) && (out_item.run_start != '0) &&
                   (out_item.run_end >= out_item.run_start);

  `IRT_ASSERT_NXT(a_hold, out_valid && out_stall, out_valid && $stable(out_item))
  `IRT_ASSERT_RST(a_rst_idle, !out_valid)
  `IRT_ASSERT_IMP(a_plain_is_run, out_valid && !out_item.stream_done, out_item.run_closed)
  `IRT_ASSERT_IMP(a_run_span, out_valid && out_item.run_closed, span_ok)
  `IRT_ASSERT_IMP(a_best_le_count, out_valid, out_item.best_run_number <= out_item.runs_so_far)

endmodule

bind increasing_run_tracker_top irt_checker u_irt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);
